FILE: rtl/core/ssg_pkg.sv
// Shared constants, types and the CORDIC angle table for the sine sample generator.
package ssg_pkg;

	localparam int MOD_STEPS  = 47;
	localparam int FRAC_STEPS = 32;
	localparam int RATE_W     = 20;
	localparam int PROD_W     = 63;
	localparam int BIG_W      = RATE_W + 16;
	localparam int CW         = 34;

	localparam logic [63:0] PH_MULT    = 64'd44798133900177;
	localparam logic [22:0] PH_MULT_LO = PH_MULT[22:0];
	localparam logic [22:0] PH_MULT_HI = PH_MULT[45:23];
	localparam logic [63:0] PH_BIAS    = (64'd32768 * PH_MULT + (64'd1 << 28)) >> 29;

	localparam logic signed [CW-1:0] CORDIC_X0    = 34'sd652032874;
	localparam logic signed [CW-1:0] TURN_HALF    = 34'sd2147483648;
	localparam logic signed [CW-1:0] TURN_QUARTER = 34'sd1073741824;

	typedef logic signed [CW-1:0] cval_t;

	function automatic logic [31:0] arc_angle(input int unsigned i);
		logic [31:0] a;
		unique case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/ssg_turn.sv
// Turn the sample index, frequency and phase into a Q0.32 angle by pipelined division.
module ssg_turn
	import ssg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  vld,
	input  logic [30:0]           sample_index,
	input  logic [31:0]           frequency,
	input  logic signed [15:0]    phase_offset,
	input  logic signed [15:0]    amplitude,
	input  logic [RATE_W-1:0]     rate,
	output logic                  theta_vld,
	output logic [31:0]           theta,
	output logic signed [15:0]    theta_amp
);

	logic [RATE_W-1:0] rt;
	logic [BIG_W-1:0]  big;
	assign rt  = (rate == '0) ? RATE_W'(1) : rate;
	assign big = {rt, 16'b0};

	// First stage: the time product and the two halves of the phase product.
	logic               vld_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [38:0]        ph_lo_s1, ph_hi_s1;
	logic signed [15:0] amp_s1;
	logic [15:0]        ph_u;
	assign ph_u = phase_offset ^ 16'h8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= PROD_W'(frequency) * PROD_W'(sample_index);
			ph_lo_s1 <= 39'(ph_u) * 39'(PH_MULT_LO);
			ph_hi_s1 <= 39'(ph_u) * 39'(PH_MULT_HI);
			amp_s1   <= amplitude;
		end
	end

	logic [63:0] ph_sum;
	logic [31:0] pt_start;
	assign ph_sum   = ({25'b0, ph_hi_s1} << 23) + {25'b0, ph_lo_s1} + (64'd1 << 28);
	assign pt_start = ph_sum[60:29] - PH_BIAS[31:0];

	// Remainder of the upper product bits by the rate, one dividend bit per stage.
	logic [RATE_W-1:0]   md_rem [MOD_STEPS+1];
	logic [46:0]         md_div [MOD_STEPS+1];
	logic [15:0]         md_low [MOD_STEPS+1];
	logic [31:0]         md_pt  [MOD_STEPS+1];
	logic signed [15:0]  md_amp [MOD_STEPS+1];
	logic                md_vld [MOD_STEPS+1];

	assign md_rem[0] = '0;
	assign md_div[0] = prod_s1[62:16];
	assign md_low[0] = prod_s1[15:0];
	assign md_pt[0]  = pt_start;
	assign md_amp[0] = amp_s1;
	assign md_vld[0] = vld_s1;

	for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
		logic [RATE_W:0] t;
		logic            ge;
		assign t  = {md_rem[i], md_div[i][46]};
		assign ge = t >= {1'b0, rt};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_vld[i+1] <= 1'b0;
			end else if (adv) begin
				md_vld[i+1] <= md_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				md_rem[i+1] <= ge ? RATE_W'(t - {1'b0, rt}) : RATE_W'(t);
				md_div[i+1] <= {md_div[i][45:0], 1'b0};
				md_low[i+1] <= md_low[i];
				md_pt[i+1]  <= md_pt[i];
				md_amp[i+1] <= md_amp[i];
			end
		end
	end

	// Fraction of the remainder over rate times 2^16, one quotient bit per stage.
	logic [BIG_W-1:0]    fr_rem [FRAC_STEPS+1];
	logic [31:0]         fr_q   [FRAC_STEPS+1];
	logic [31:0]         fr_pt  [FRAC_STEPS+1];
	logic signed [15:0]  fr_amp [FRAC_STEPS+1];
	logic                fr_vld [FRAC_STEPS+1];

	assign fr_rem[0] = {md_rem[MOD_STEPS], md_low[MOD_STEPS]};
	assign fr_q[0]   = '0;
	assign fr_pt[0]  = md_pt[MOD_STEPS];
	assign fr_amp[0] = md_amp[MOD_STEPS];
	assign fr_vld[0] = md_vld[MOD_STEPS];

	for (genvar j = 0; j < FRAC_STEPS; j++) begin : g_frac
		logic [BIG_W:0] t;
		logic           ge;
		assign t  = {fr_rem[j], 1'b0};
		assign ge = t >= {1'b0, big};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fr_vld[j+1] <= 1'b0;
			end else if (adv) begin
				fr_vld[j+1] <= fr_vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fr_rem[j+1] <= ge ? BIG_W'(t - {1'b0, big}) : BIG_W'(t);
				fr_q[j+1]   <= {fr_q[j][30:0], ge};
				fr_pt[j+1]  <= fr_pt[j];
				fr_amp[j+1] <= fr_amp[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_vld <= 1'b0;
		end else if (adv) begin
			theta_vld <= fr_vld[FRAC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			theta     <= fr_q[FRAC_STEPS] + fr_pt[FRAC_STEPS];
			theta_amp <= fr_amp[FRAC_STEPS];
		end
	end

endmodule

FILE: rtl/core/ssg_cordic.sv
// Quadrant fold and pipelined rotation-mode CORDIC giving the sine in signed Q3.30.
module ssg_cordic
	import ssg_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld,
	input  logic [31:0]        theta,
	input  logic signed [15:0] amp,
	output logic               sin_vld,
	output cval_t              sin_y,
	output logic signed [15:0] sin_amp
);

	cval_t zs, zf;
	assign zs = CW'(signed'(theta));

	always_comb begin
		priority if (zs > TURN_QUARTER) begin
			zf = TURN_HALF - zs;
		end else if (zs < -TURN_QUARTER) begin
			zf = -TURN_HALF - zs;
		end else begin
			zf = zs;
		end
	end

	cval_t              cx [CORDIC_STAGES+1];
	cval_t              cy [CORDIC_STAGES+1];
	cval_t              cz [CORDIC_STAGES+1];
	logic signed [15:0] ca [CORDIC_STAGES+1];
	logic               cv [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else if (adv) begin
			cv[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx[0] <= CORDIC_X0;
			cy[0] <= '0;
			cz[0] <= zf;
			ca[0] <= amp;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic [31:0] ARC = arc_angle(i);
		cval_t dx, dy, arc;
		assign dx  = cy[i] >>> i;
		assign dy  = cx[i] >>> i;
		assign arc = cval_t'({2'b00, ARC});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv[i+1] <= 1'b0;
			end else if (adv) begin
				cv[i+1] <= cv[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cz[i] >= 0) begin
					cx[i+1] <= cx[i] - dx;
					cy[i+1] <= cy[i] + dy;
					cz[i+1] <= cz[i] - arc;
				end else begin
					cx[i+1] <= cx[i] + dx;
					cy[i+1] <= cy[i] - dy;
					cz[i+1] <= cz[i] + arc;
				end
				ca[i+1] <= ca[i];
			end
		end
	end

	assign sin_vld = cv[CORDIC_STAGES];
	assign sin_y   = cy[CORDIC_STAGES];
	assign sin_amp = ca[CORDIC_STAGES];

endmodule

FILE: rtl/core/sine_sample_generator.sv
// Top level of the sine sample generator: rate register, pipeline and scaled output.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | sample_index, amplitude, frequency, phase_offset
//  output   | out_valid / out_stall  | sample_value
//  config   | cfg_valid / cfg_ready  | cfg_data (rate_of_sampling)
//
// One item can enter every cycle while the output is not stalled.
// The angle divider has 47 remainder steps and 32 quotient steps.
// Reset clears all valid bits and sets the rate to 48000; the config port is always ready.
// A stalled output holds the whole pipeline, so no transaction is lost or repeated.
module sine_sample_generator
	import ssg_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int OUT_WIDTH     = 16
)
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [30:0]                 sample_index,
	input  logic signed [15:0]          amplitude,
	input  logic [31:0]                 frequency,
	input  logic signed [15:0]          phase_offset,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_WIDTH-1:0] sample_value,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [RATE_W-1:0]           cfg_data
);

	localparam int SH = 46 - OUT_WIDTH;
	localparam logic signed [50:0] MAXV = (51'sd1 <<< (OUT_WIDTH - 1)) - 51'sd1;
	localparam logic signed [50:0] MINV = -MAXV - 51'sd1;
	localparam logic signed [50:0] RND  = 51'sd1 <<< (SH - 1);

	logic [RATE_W-1:0] rate_q;
	logic              adv;

	assign cfg_ready = 1'b1;
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(48000);
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	logic               th_vld;
	logic [31:0]        th;
	logic signed [15:0] th_amp;

	ssg_turn u_turn (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.vld          (in_valid),
		.sample_index (sample_index),
		.frequency    (frequency),
		.phase_offset (phase_offset),
		.amplitude    (amplitude),
		.rate         (rate_q),
		.theta_vld    (th_vld),
		.theta        (th),
		.theta_amp    (th_amp)
	);

	logic               sn_vld;
	cval_t              sn_y;
	logic signed [15:0] sn_amp;

	ssg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld     (th_vld),
		.theta   (th),
		.amp     (th_amp),
		.sin_vld (sn_vld),
		.sin_y   (sn_y),
		.sin_amp (sn_amp)
	);

	logic                    mul_vld_q;
	logic signed [CW+15:0]   mul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_q <= 1'b0;
		end else if (adv) begin
			mul_vld_q <= sn_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_q <= (CW+16)'(sn_amp) * (CW+16)'(sn_y);
		end
	end

	logic signed [50:0] rnd;
	logic signed [50:0] sat;
	assign rnd = (51'(mul_q) + RND) >>> SH;

	always_comb begin
		priority if (rnd > MAXV) begin
			sat = MAXV;
		end else if (rnd < MINV) begin
			sat = MINV;
		end else begin
			sat = rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= mul_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_value <= sat[OUT_WIDTH-1:0];
		end
	end

	// A configuration transaction lands in the rate register on the next edge.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> rate_q == $past(cfg_data))
		else $error("rate register did not take the written value");

	// A result can only appear if the product stage held an item.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(mul_vld_q))
		else $error("result appeared without an item in the product stage");

	// While the output is held the product stage must not move.
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mul_vld_q) && $stable(mul_q))
		else $error("pipeline moved while the output was held");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the sine sample generator with random traffic and rate changes.
module testbench
	import ssg_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY  = 84 + 16;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic [30:0]        idx;
		logic signed [15:0] amp;
		logic [31:0]        freq;
		logic signed [15:0] phase;
	} tone_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [30:0]         sample_index = '0;
	logic signed [15:0]  amplitude = '0;
	logic [31:0]         frequency = '0;
	logic signed [15:0]  phase_offset = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic signed [15:0]  sample_value;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RATE_W-1:0]   cfg_data = '0;

	tone_req_t          pending_reqs[$];
	logic signed [15:0] expected_samples[$];
	logic [19:0]        rate_now = 20'd48000;
	int                 fail_count = 0;
	int                 idle_cycles = 0;
	int                 gap_left = 0;
	int                 stall_left = 0;

	sine_sample_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_index(sample_index), .amplitude(amplitude),
		.frequency(frequency), .phase_offset(phase_offset),
		.out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [15:0] predict_sample(tone_req_t r, logic [19:0] rate);
		logic [63:0]  big, rem, prod;
		logic [31:0]  q, pt, theta;
		logic [63:0]  u, a, b;
		longint       z, x, y, dx, dy, v, amp;
		big  = {28'd0, (rate == 0) ? 20'd1 : rate, 16'd0};
		prod = 64'(r.freq) * 64'(r.idx);
		rem  = prod % big;
		q    = '0;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= big) begin
				rem  = rem - big;
				q[0] = 1'b1;
			end
		end
		u     = {48'd0, r.phase ^ 16'h8000};
		a     = (u * PH_MULT + (64'd1 << 28)) >> 29;
		b     = (64'd32768 * PH_MULT + (64'd1 << 28)) >> 29;
		pt    = 32'(a - b);
		theta = q + pt;
		z     = longint'($signed(theta));
		if (z > 64'sd1073741824)
			z = 64'sd2147483648 - z;
		else if (z < -64'sd1073741824)
			z = -64'sd2147483648 - z;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_sh(y, i);
			dy = floor_sh(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(arc_angle(i));
			end else begin
				x += dx; y -= dy; z += longint'(arc_angle(i));
			end
		end
		amp = longint'(r.amp);
		v   = floor_sh(amp * y + (64'sd1 <<< 29), 30);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		else if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic tone_req_t random_req();
		tone_req_t r;
		int        mode;
		r.idx   = 31'($urandom);
		r.amp   = 16'($urandom);
		r.freq  = $urandom;
		r.phase = 16'($urandom);
		mode = $urandom_range(5);
		// Half are audible tones at modest indices, the rest raw full-range values, some at full-scale amplitude.
		if (mode < 3) begin
			r.freq = $urandom_range(32'd20000 << 16);
			r.idx  = 31'($urandom_range(1000000));
		end else if (mode == 3) begin
			r.amp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		end
		return r;
	endfunction

	// Driver: inputs change only at the edge, with a stalled transaction held.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_samples.push_back(predict_sample('{sample_index, amplitude,
					frequency, phase_offset}, rate_now));
				gap_left = pick_gap();
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_reqs.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					tone_req_t r;
					r = pending_reqs.pop_front();
					in_valid     <= 1'b1;
					sample_index <= r.idx;
					amplitude    <= r.amp;
					frequency    <= r.freq;
					phase_offset <= r.phase;
				end
			end
		end
	end

	// Monitor: checks each output transaction and drives random back-pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$error("sample_value: no expectation waiting, actual %0d", sample_value);
					fail_count++;
				end else begin
					logic signed [15:0] want;
					want = expected_samples.pop_front();
					if (want !== sample_value) begin
						$error("sample_value: expected %0d, actual %0d", want, sample_value);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_stall <= 1'b0;
			end
			if (idle_cycles > WATCHDOG) begin
				$display("sine_sample_generator regression: fail");
				$finish;
			end
		end
	end

	task automatic write_rate(logic [19:0] rate);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= rate;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rate_now = rate;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		logic [19:0] rates[6];
		rates = '{20'd48000, 20'd1, 20'd0, 20'hFFFFF, 20'd44100, 20'd8000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: field extremes, zero rate, full negative amplitude at sine minimum.
		pending_reqs.push_back('{31'd0, 16'sh7fff, 32'd0, 16'sh0000});
		pending_reqs.push_back('{31'h7fffffff, 16'sh7fff, 32'hffffffff, 16'sh7fff});
		pending_reqs.push_back('{31'h7fffffff, 16'sh8000, 32'hffffffff, 16'sh8000});
		pending_reqs.push_back('{31'd0, 16'sh8000, 32'd0, -16'sd12868});
		pending_reqs.push_back('{31'd0, 16'sh8000, 32'd0, 16'sd12868});
		pending_reqs.push_back('{31'd0, 16'sh7fff, 32'd0, 16'sd12868});
		pending_reqs.push_back('{31'd12000, 16'sh4000, 32'd1000 << 16, 16'sd0});
		pending_reqs.push_back('{31'd36000, 16'sh8000, 32'd1 << 16, 16'sd0});
		pending_reqs.push_back('{31'd1, 16'sh0000, 32'd1, 16'sh0001});
		pending_reqs.push_back('{31'd1, 16'shffff, 32'd12000 << 16, 16'shffff});
		foreach (rates[k]) begin
			if (k > 0)
				write_rate(rates[k]);
			if (k == 2) begin
				pending_reqs.push_back('{31'd5, 16'sh7fff, 32'h00004000, 16'sd0});
				pending_reqs.push_back('{31'h7fffffff, 16'sh8000, 32'hffffffff, 16'sd0});
			end
			repeat (225) pending_reqs.push_back(random_req());
			drain();
		end
		if (fail_count == 0)
			$display("sine_sample_generator regression: pass");
		else
			$display("sine_sample_generator regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_turn.sv
rtl/core/ssg_cordic.sv
rtl/core/sine_sample_generator.sv
verif/testbench.sv
